// ===== rtl/pds_pkg.sv =====
// Shared types and constants for the pass dependency sorter.
// No dependencies; imported by every module of the block.
package pds_pkg;

    localparam int MaxPasses    = 16;
    localparam int MaxResources = 16;
    localparam int PassW        = $clog2(MaxPasses);
    localparam int CntW         = $clog2(MaxPasses + 1);
    localparam int ResW         = $clog2(MaxResources);

    localparam logic [2:0] OP_READ  = 3'd0;
    localparam logic [2:0] OP_WRITE = 3'd1;
    localparam logic [2:0] OP_END   = 3'd2;
    localparam logic [2:0] OP_SORT  = 3'd3;
    localparam logic [2:0] OP_CLEAR = 3'd4;

    typedef struct packed {
        logic [2:0]      operation;
        logic [ResW-1:0] resource;
    } t_in_word;

    typedef struct packed {
        logic [PassW-1:0] pass_number;
        logic             last;
        logic             fell_back;
        logic             empty_graph;
    } t_out_word;

    typedef logic [MaxPasses-1:0] t_row;
    typedef logic [CntW-1:0]      t_cnt;
    typedef t_cnt [MaxPasses-1:0] t_deg_vec;

    typedef struct packed {
        logic             rd_en;
        logic [PassW-1:0] rd_addr;
    } t_rd_req;

    typedef struct packed {
        logic             wr_en;
        logic [PassW-1:0] wr_addr;
        t_row             wr_data;
    } t_wr_req;

endpackage

// ===== rtl/pds_edge_mem.sv =====
// Edge matrix storage: one row per producing pass, bit q set when pass q depends on it.
// Synchronous memory, one read and one write port, per-row valid bits for fast clear.
// Depends on pds_pkg.
module pds_edge_mem (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_clear,
    input  pds_pkg::t_rd_req i_rd,
    input  pds_pkg::t_wr_req i_wr,
    output pds_pkg::t_row    o_rd_data
);
    import pds_pkg::*;

    t_row                 r_mem [MaxPasses];
    t_row                 r_rd_data;
    logic                 r_rd_vld;
    logic [MaxPasses-1:0] r_row_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr.wr_en) begin
            r_mem[i_wr.wr_addr] <= i_wr.wr_data;
        end
        if (i_rd.rd_en) begin
            r_rd_data <= r_mem[i_rd.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (i_wr.wr_en) begin
                r_row_vld[i_wr.wr_addr] <= 1'b1;
            end
            if (i_rd.rd_en) begin
                r_rd_vld <= r_row_vld[i_rd.rd_addr];
            end
        end
    end

    // a row never written reads as all zero
    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

// ===== rtl/pds_sort.sv =====
// Sort engine: Kahn's algorithm with a LIFO ready stack, then emits the order.
// Reads edge rows from pds_edge_mem; works on a private copy of the in-degrees.
// Depends on pds_pkg.
module pds_sort (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  pds_pkg::t_cnt      i_n,
    input  pds_pkg::t_deg_vec  i_indeg,
    output pds_pkg::t_rd_req   o_rd,
    input  pds_pkg::t_row      i_rd_data,
    output logic               o_busy,
    output logic               o_strobe,
    output pds_pkg::t_out_word o_result
);
    import pds_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_POP,
        S_COL,
        S_EMIT
    } t_state;

    t_state           r_state;
    t_cnt             r_n;
    t_cnt             r_depth;
    t_cnt             r_placed;
    logic [PassW-1:0] r_idx;
    logic             r_fell;
    t_deg_vec         r_deg;
    logic [PassW-1:0] r_stack [MaxPasses];
    logic [PassW-1:0] r_order [MaxPasses];

    t_cnt             w_top;
    t_cnt             w_deg_cur;
    logic             w_last_idx;
    logic             w_can_pop;
    logic             w_pop;
    logic             w_push;
    logic             w_dec;

    always_comb begin
        w_top      = r_depth - 1'b1;
        w_deg_cur  = r_deg[r_idx];
        w_last_idx = (CntW'(r_idx) == r_n - 1'b1);
        w_can_pop  = (r_depth != '0) && (r_placed < CntW'(MaxPasses));
        w_pop      = (r_state == S_POP) && w_can_pop;
        w_dec      = (r_state == S_COL) && i_rd_data[r_idx] && (w_deg_cur != '0);
        case (r_state)
            S_SCAN:  w_push = (w_deg_cur == '0) && (r_depth < CntW'(MaxPasses));
            S_COL:   w_push = w_dec && (w_deg_cur == t_cnt'(1))
                              && (r_depth < CntW'(MaxPasses));
            default: w_push = 1'b0;
        endcase
    end

    assign o_rd.rd_en   = w_pop;
    assign o_rd.rd_addr = r_stack[w_top[PassW-1:0]];
    assign o_busy       = (r_state != S_IDLE);

    // scratch tables, no reset needed
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_deg <= i_indeg;
        end else if (w_dec) begin
            r_deg[r_idx] <= w_deg_cur - 1'b1;
        end
        if (w_push) begin
            r_stack[r_depth[PassW-1:0]] <= r_idx;
        end
        if (w_pop) begin
            r_order[r_placed[PassW-1:0]] <= r_stack[w_top[PassW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_n      <= '0;
            r_depth  <= '0;
            r_placed <= '0;
            r_idx    <= '0;
            r_fell   <= 1'b0;
            o_strobe <= 1'b0;
            o_result <= '0;
        end else begin
            o_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        if (i_n == '0) begin
                            o_result <= '{pass_number: '0, last: 1'b1,
                                          fell_back: 1'b0, empty_graph: 1'b1};
                            o_strobe <= 1'b1;
                        end else begin
                            r_n      <= i_n;
                            r_idx    <= '0;
                            r_depth  <= '0;
                            r_placed <= '0;
                            r_fell   <= 1'b0;
                            r_state  <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (w_push) begin
                        r_depth <= r_depth + 1'b1;
                    end
                    if (w_last_idx) begin
                        r_idx   <= '0;
                        r_state <= S_POP;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_POP: begin
                    r_idx <= '0;
                    if (w_can_pop) begin
                        r_depth  <= r_depth - 1'b1;
                        r_placed <= r_placed + 1'b1;
                        r_state  <= S_COL;
                    end else begin
                        // a cycle leaves passes unplaced
                        r_fell  <= (r_placed != r_n);
                        r_state <= S_EMIT;
                    end
                end
                S_COL: begin
                    // row of the popped pass sits on the memory output
                    if (w_push) begin
                        r_depth <= r_depth + 1'b1;
                    end
                    if (w_last_idx) begin
                        r_idx   <= '0;
                        r_state <= S_POP;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_EMIT: begin
                    o_result.pass_number <= r_fell ? r_idx : r_order[r_idx];
                    o_result.last        <= w_last_idx;
                    o_result.fell_back   <= r_fell;
                    o_result.empty_graph <= 1'b0;
                    o_strobe             <= 1'b1;
                    if (w_last_idx) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= CntW'(MaxPasses))
        else $error("ready stack overflow");

    a_placed_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_placed <= r_n)
        else $error("more passes placed than exist");

    a_emit_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |=> o_strobe)
        else $error("emit cycle without result strobe");

endmodule

// ===== rtl/pass_dependency_topo_sort.sv =====
// Pass dependency sorter, top level: graph build tables and edge memory arbitration.
// Instantiates pds_edge_mem and pds_sort; depends on pds_pkg.
//
// Usage: drive i_cmd and raise start; the word is taken on a clock edge where
// busy is low. Commands: read resource, write resource, end pass, sort, clear.
// Write, end pass, clear, unused codes and reads of a resource with no
// committed producer do not hold busy. A read that finds an earlier producer
// does a read-modify-write of that producer's row in the edge memory and holds
// busy for the next cycle, whether or not the edge is new.
// Sort with n committed passes: a scan over all n passes seeds the ready
// stack, then each placed pass takes a pop (edge row read) and a walk over the
// n columns, a final pop finds the stack empty, then one emit step per pass;
// busy is high through all of them. Results appear on o_result with o_strobe
// high for exactly one cycle each, in the cycle after their emit step, in
// order, the final one flagged last. With no passes a single empty_graph
// result comes in the cycle after start. The receiver cannot stall; every
// strobed word must be captured.
// Reset (synchronous, active low) and the clear command empty all tables;
// edge rows are cleared at once through per-row valid bits.
module pass_dependency_topo_sort (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  pds_pkg::t_in_word  i_cmd,
    output logic               busy,
    output logic               o_strobe,
    output pds_pkg::t_out_word o_result
);
    import pds_pkg::*;

    logic [MaxResources-1:0] r_prod_vld;
    logic [PassW-1:0]        r_prod [MaxResources];
    logic [MaxResources-1:0] r_pending;
    t_deg_vec                r_indeg;
    t_cnt                    r_pass_total;
    logic                    r_rmw;
    logic [PassW-1:0]        r_rmw_row;

    logic                    w_acc;
    logic                    w_open;
    logic [PassW-1:0]        w_cur;
    logic                    w_sort_busy;
    logic                    w_sort_start;
    logic                    w_clear;
    logic                    w_new_edge;
    t_rd_req                 w_build_rd;
    t_rd_req                 w_sort_rd;
    t_rd_req                 w_rd;
    t_wr_req                 w_wr;
    t_row                    w_row;

    assign busy         = r_rmw || w_sort_busy;
    assign w_acc        = start && !busy;
    assign w_open       = (r_pass_total < CntW'(MaxPasses));
    assign w_cur        = r_pass_total[PassW-1:0];
    assign w_sort_start = w_acc && (i_cmd.operation == OP_SORT);
    assign w_clear      = w_acc && (i_cmd.operation == OP_CLEAR);

    always_comb begin
        w_build_rd.rd_en   = w_acc && (i_cmd.operation == OP_READ) && w_open
                             && r_prod_vld[i_cmd.resource]
                             && (r_prod[i_cmd.resource] != w_cur);
        w_build_rd.rd_addr = r_prod[i_cmd.resource];
        w_rd               = w_sort_rd.rd_en ? w_sort_rd : w_build_rd;
        // count each distinct predecessor once
        w_new_edge         = r_rmw && !w_row[w_cur];
        w_wr.wr_en         = w_new_edge;
        w_wr.wr_addr       = r_rmw_row;
        w_wr.wr_data       = w_row | (t_row'(1) << w_cur);
    end

    pds_edge_mem u_edge_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (w_clear),
        .i_rd      (w_rd),
        .i_wr      (w_wr),
        .o_rd_data (w_row)
    );

    pds_sort u_sort (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_sort_start),
        .i_n       (r_pass_total),
        .i_indeg   (r_indeg),
        .o_rd      (w_sort_rd),
        .i_rd_data (w_row),
        .o_busy    (w_sort_busy),
        .o_strobe  (o_strobe),
        .o_result  (o_result)
    );

    always_ff @(posedge i_clk) begin
        if (w_acc && (i_cmd.operation == OP_END) && w_open) begin
            for (int r = 0; r < MaxResources; r++) begin
                if (r_pending[r]) begin
                    r_prod[r] <= w_cur;
                end
            end
        end
        if (w_build_rd.rd_en) begin
            r_rmw_row <= w_build_rd.rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld   <= '0;
            r_pending    <= '0;
            r_indeg      <= '0;
            r_pass_total <= '0;
            r_rmw        <= 1'b0;
        end else begin
            r_rmw <= w_build_rd.rd_en;
            if (w_new_edge) begin
                r_indeg[w_cur] <= r_indeg[w_cur] + 1'b1;
            end
            if (w_acc) begin
                case (i_cmd.operation)
                    OP_WRITE: begin
                        if (w_open) begin
                            r_pending[i_cmd.resource] <= 1'b1;
                        end
                    end
                    OP_END: begin
                        if (w_open) begin
                            r_prod_vld   <= r_prod_vld | r_pending;
                            r_pending    <= '0;
                            r_pass_total <= r_pass_total + 1'b1;
                        end
                    end
                    OP_CLEAR: begin
                        r_prod_vld   <= '0;
                        r_pending    <= '0;
                        r_indeg      <= '0;
                        r_pass_total <= '0;
                    end
                    default: ;
                endcase
            end
        end
    end

    a_rmw_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rmw |=> !r_rmw)
        else $error("edge update held busy for more than one cycle");

    a_wr_not_sorting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr.wr_en |-> !w_sort_busy)
        else $error("edge row written while sorting");

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pass_total <= CntW'(MaxPasses))
        else $error("pass count beyond limit");

endmodule
